FILE: src/velocity_observer_fault_mode_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the velocity observer block.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_OBSERVER_FAULT_MODE_ASSERT_SVH
`define VELOCITY_OBSERVER_FAULT_MODE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define VOFM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define VOFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/vofm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vofm_pkg
// Types and constants shared by the velocity observer and fault mode block.
// ----------------------------------------------------------------------------
package vofm_pkg;

   localparam int VEL_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int THR_W   = 15;
   localparam int INDEX_W = 3;

   // Register indexes on the configuration port.
   localparam logic [INDEX_W-1:0] REG_GAIN_A    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_GAIN_B    = 3'd1;
   localparam logic [INDEX_W-1:0] REG_GAIN_L    = 3'd2;
   localparam logic [INDEX_W-1:0] REG_THRESHOLD = 3'd3;
   localparam logic [INDEX_W-1:0] REG_IS_LEADER = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_A_RESET    = 16'd22338;
   localparam logic [GAIN_W-1:0] GAIN_B_RESET    = 16'd10430;
   localparam logic [GAIN_W-1:0] GAIN_L_RESET    = 16'd9231;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 15'd256;

   // Command used while encoder fault injection is on: 2.0 in Q8.8.
   localparam logic signed [VEL_W-1:0] U_INJECTED = 16'sd512;

   // Rounding bias for the Q.23 to Q8.8 conversion.
   localparam logic signed [35:0] ROUND_HALF = 36'sd16384;

   localparam logic signed [20:0] EST_MAX = 21'sd32767;
   localparam logic signed [20:0] EST_MIN = -21'sd32768;

   // Coordinator mode codes.
   localparam logic [1:0] COORD_NORMAL    = 2'd0;
   localparam logic [1:0] COORD_RESILIENT = 2'd1;
   localparam logic [1:0] COORD_DEGRADED  = 2'd2;

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_RESILIENT = 2'd1,
      MODE_DEGRADED  = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] measured_vel;
      logic signed [VEL_W-1:0] applied_vel;
      logic                    encoder_fault_inject;
      logic                    camera_fault;
      logic                    link_fault;
      logic [1:0]              coord_mode;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] estimated_vel;
      logic                    vel_fault;
      logic [1:0]              op_mode;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_a;
      logic [GAIN_W-1:0] gain_b;
      logic [GAIN_W-1:0] gain_l;
      logic [THR_W-1:0]  fault_threshold;
      logic              is_leader;
   } cfg_type;

endpackage

FILE: src/vofm_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vofm_csr
// Configuration registers: observer gains, fault threshold and leader select.
// ----------------------------------------------------------------------------
module vofm_csr
   import vofm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0]   csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GAIN_A:    cfg_in.gain_a          = csr_wdata;
            REG_GAIN_B:    cfg_in.gain_b          = csr_wdata;
            REG_GAIN_L:    cfg_in.gain_l          = csr_wdata;
            REG_THRESHOLD: cfg_in.fault_threshold = csr_wdata[THR_W-1:0];
            REG_IS_LEADER: cfg_in.is_leader       = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_a          <= GAIN_A_RESET;
         cfg_ff.gain_b          <= GAIN_B_RESET;
         cfg_ff.gain_l          <= GAIN_L_RESET;
         cfg_ff.fault_threshold <= THRESHOLD_RESET;
         cfg_ff.is_leader       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/vofm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vofm_core
// Observer update, residual fault latch and operating mode selection.
// ----------------------------------------------------------------------------
`include "velocity_observer_fault_mode_assert.svh"

module vofm_core
   import vofm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic signed [VEL_W-1:0] estimate_ff;
   logic signed [VEL_W-1:0] estimate_in;
   logic                    fault_latch_ff;
   logic                    fault_latch_in;
   mode_type                mode_ff;
   mode_type                mode_in;

   logic signed [VEL_W-1:0] y_val;
   logic signed [VEL_W-1:0] u_val;
   logic signed [VEL_W:0]   diff;
   logic signed [32:0]      prod_a;
   logic signed [32:0]      prod_b;
   logic signed [33:0]      prod_l;
   logic signed [35:0]      acc;
   logic signed [20:0]      rounded;
   logic signed [VEL_W:0]   resid;
   logic [VEL_W:0]          resid_mag;
   logic                    crc01;
   logic                    any_fault;

   // Observer update: three products summed exactly in Q.23.
   always_comb begin
      if (item.encoder_fault_inject) begin
         y_val = '0;
         u_val = U_INJECTED;
      end else begin
         y_val = item.measured_vel;
         u_val = item.applied_vel;
      end
      diff   = 17'(y_val) - 17'(estimate_ff);
      prod_a = $signed({1'b0, cfg.gain_a}) * estimate_ff;
      prod_b = $signed({1'b0, cfg.gain_b}) * u_val;
      prod_l = $signed({1'b0, cfg.gain_l}) * diff;
      acc    = 36'(prod_a) + 36'(prod_b) - 36'(prod_l) + ROUND_HALF;
      // The arithmetic shift floors, so ties round toward plus infinity.
      rounded = 21'(acc >>> 15);
      if (rounded > EST_MAX) begin
         estimate_in = EST_MAX[VEL_W-1:0];
      end else if (rounded < EST_MIN) begin
         estimate_in = EST_MIN[VEL_W-1:0];
      end else begin
         estimate_in = rounded[VEL_W-1:0];
      end
   end

   // Residual test against the saturated new estimate.
   always_comb begin
      resid          = 17'(y_val) - 17'(estimate_in);
      resid_mag      = resid[VEL_W] ? 17'(-resid) : 17'(resid);
      fault_latch_in = fault_latch_ff | (resid_mag > {2'b00, cfg.fault_threshold});
   end

   // Mode selection uses the latch value just updated; otherwise hold.
   always_comb begin
      crc01     = (item.coord_mode == COORD_NORMAL) || (item.coord_mode == COORD_RESILIENT);
      any_fault = fault_latch_in | item.camera_fault | item.link_fault;
      mode_in   = mode_ff;
      if (cfg.is_leader) begin
         if (item.camera_fault || item.coord_mode == COORD_DEGRADED) begin
            mode_in = MODE_DEGRADED;
         end else if ((fault_latch_in || item.link_fault) && crc01) begin
            mode_in = MODE_RESILIENT;
         end else if (item.coord_mode == COORD_NORMAL || !any_fault) begin
            mode_in = MODE_NORMAL;
         end
      end else begin
         if ((item.camera_fault && item.link_fault) || item.coord_mode == COORD_DEGRADED) begin
            mode_in = MODE_DEGRADED;
         end else if (any_fault && crc01) begin
            mode_in = MODE_RESILIENT;
         end else if (item.coord_mode == COORD_NORMAL || !any_fault) begin
            mode_in = MODE_NORMAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         estimate_ff    <= '0;
         fault_latch_ff <= 1'b0;
         mode_ff        <= MODE_NORMAL;
      end else if (fire) begin
         estimate_ff    <= estimate_in;
         fault_latch_ff <= fault_latch_in;
         mode_ff        <= mode_in;
      end
   end

   assign result.estimated_vel = estimate_in;
   assign result.vel_fault     = fault_latch_in;
   assign result.op_mode       = mode_in;

   `VOFM_ASSERT(a_latch_sticky, clock, reset,
      fault_latch_ff |=> fault_latch_ff, "fault latch cleared without reset")
   `VOFM_ASSERT(a_estimate_hold, clock, reset,
      !fire |=> $stable(estimate_ff), "estimate changed without an item")
   `VOFM_ASSERT(a_mode_hold, clock, reset,
      !fire |=> $stable(mode_ff), "mode changed without an item")

endmodule

FILE: src/velocity_observer_fault_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_observer_fault_mode
// Velocity observer with residual fault latch and operating mode selection.
// ----------------------------------------------------------------------------
// A request word accepted into the input register moves on as a response word
// when the output register is free or drains. Throughput: one word per cycle
// unless rsp_ready holds the output; the observer update is a single pass from
// the input register through three parallel multipliers to the output register.
// Reset (synchronous, active high) clears the estimate, the fault latch and the
// mode, empties both stages and restores the register defaults.
`include "velocity_observer_fault_mode_assert.svh"

module velocity_observer_fault_mode
   import vofm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff;
   rsp_type out_data_ff;
   logic    out_valid_ff;
   rsp_type core_result;
   logic    advance;
   logic    fire;

   // The stage moves forward whenever the output register is free or drains.
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   vofm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vofm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_data_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `VOFM_ASSERT(a_stage_moves, clock, reset,
      in_valid_ff && !out_valid_ff |=> out_valid_ff, "word lost between stages")
   `VOFM_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response word not held")
   `VOFM_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid, "response valid right after reset")

endmodule
